// ----- hdl/clnws_pkg.sv -----
// ----------------------------------------------------------------------------
// clnws_pkg
// Types and constants shared by the 4-bit character LCD write sequencer.
// ----------------------------------------------------------------------------
package clnws_pkg;

    // request codes carried in the func field
    localparam logic [1:0] FUNC_TICK = 2'd0;
    localparam logic [1:0] FUNC_CMD  = 2'd1;
    localparam logic [1:0] FUNC_DATA = 2'd2;
    localparam logic [1:0] FUNC_INIT = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_HIGH    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE_GAP     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_WAIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_WAIT      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_POWERUP        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_FIRST_GAP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_INIT_NEXT_GAP  = 3'd6;
    localparam int unsigned CFG_DATA_W = 16;

    // sequencer phases
    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_POWERUP = 3'd1;
    localparam logic [2:0] PH_EN_HIGH = 3'd2;
    localparam logic [2:0] PH_EN_GAP  = 3'd3;
    localparam logic [2:0] PH_POST    = 3'd4;

    // init progress codes
    localparam logic [3:0] STEP_NONE       = 4'd0;
    localparam logic [3:0] STEP_NIB_FIRST  = 4'd1;
    localparam logic [3:0] STEP_NIB_NEXT   = 4'd3;
    localparam logic [3:0] STEP_NIB_LAST   = 4'd4;
    localparam logic [3:0] STEP_CMD_FIRST  = 4'd5;
    localparam logic [3:0] STEP_CMD_LAST   = 4'd8;
    localparam logic [3:0] STEP_CLEAR_WAIT = 4'd9;

    // init nibbles and commands
    localparam logic [3:0] NIB_WAKE     = 4'h3;
    localparam logic [3:0] NIB_FOUR_BIT = 4'h2;
    localparam logic [7:0] INIT_CMDS [4] = '{8'h28, 8'h06, 8'h0F, 8'h01};
    localparam logic [7:0] CMD_LONG_LIMIT = 8'd4;

    typedef struct packed {
        logic [7:0]  enable_high;
        logic [15:0] enable_gap;
        logic [15:0] short_wait;
        logic [15:0] long_wait;
        logic [15:0] powerup;
        logic [15:0] init_first_gap;
        logic [15:0] init_next_gap;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  phase;
        logic [15:0] wait_count;
        logic [7:0]  held_byte;
        logic        low_nibble_next;
        logic [3:0]  init_step;
        logic        rs_level;
        logic        enable_level;
        logic [3:0]  data_level;
    } t_state;

    typedef struct packed {
        logic       pin_rs;
        logic       pin_enable;
        logic [3:0] pin_data;
        logic       busy_res;
        logic       rejected;
    } t_result;

endpackage

// ----- hdl/clnws_if.sv -----
// ----------------------------------------------------------------------------
// clnws channel interfaces
// Request, result and configuration channels with valid/ready handshakes.
// ----------------------------------------------------------------------------

// request channel
interface clnws_in_if import clnws_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] func;
    logic [7:0] byte_value;

    modport source (output valid, output func, output byte_value, input ready);
    modport sink (input valid, input func, input byte_value, output ready);
endinterface

// result channel
interface clnws_out_if import clnws_pkg::*; ();
    logic       valid;
    logic       ready;
    logic       pin_rs;
    logic       pin_enable;
    logic [3:0] pin_data;
    logic       busy_res;
    logic       rejected;

    modport source (output valid, output pin_rs, output pin_enable, output pin_data,
                    output busy_res, output rejected, input ready);
    modport sink (input valid, input pin_rs, input pin_enable, input pin_data,
                  input busy_res, input rejected, output ready);
endinterface

// configuration write channel
interface clnws_cfg_if import clnws_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// ----- hdl/char_lcd_nibble_write_sequencer.sv -----
// ----------------------------------------------------------------------------
// char_lcd_nibble_write_sequencer
// Sends command and data bytes to a character LCD as two nibbles each over a
// 4-bit bus, timed by microsecond tick beats, with a built-in init sequence.
// ----------------------------------------------------------------------------
//  channel  | dir | port   | beat
//  ---------+-----+--------+------------------------------------------------
//  request  | in  | i_in   | func, byte_value (tick, command, data, init)
//  result   | out | o_out  | pin_rs, pin_enable, pin_data, busy_res, rejected
//  config   | in  | i_cfg  | index, data (register write)
//
//  One request beat is taken every cycle while the result side is not stalled;
//  its result beat is registered and appears the cycle after acceptance.
//  A request is taken while the result register is empty or being drained,
//  so a stalled result holds the request side only until it is taken.
//  Zero-length waits are resolved within the same beat by a short chain of
//  at most five phase steps ahead of the state register.
//  Reset (i_rst_n low, synchronous) clears the sequencer to idle with all
//  pins low and loads the default timing registers. Config is always ready.
// ----------------------------------------------------------------------------
module char_lcd_nibble_write_sequencer
    import clnws_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    clnws_in_if.sink    i_in,
    clnws_out_if.source o_out,
    clnws_cfg_if.sink   i_cfg
);

    localparam int unsigned SETTLE_STEPS = 5;

    t_cfg    r_cfg;
    t_state  r_st, n_st;
    t_result r_res, n_res;
    logic    r_out_valid;
    logic    w_in_acc;
    logic    w_out_acc;

    // put a nibble on the pins and raise enable
    function automatic t_state f_start_nibble(t_state s, logic [3:0] nib, logic rs,
                                              t_cfg c);
        t_state r;
        r = s;
        r.rs_level     = rs;
        r.data_level   = nib;
        r.enable_level = 1'b1;
        r.phase        = PH_EN_HIGH;
        r.wait_count   = (c.enable_high == 8'd0) ? 16'd1 : {8'd0, c.enable_high};
        return r;
    endfunction

    function automatic t_state f_start_byte(t_state s, logic [7:0] b, logic rs, t_cfg c);
        t_state r;
        r = s;
        r.held_byte       = b;
        r.low_nibble_next = 1'b1;
        return f_start_nibble(r, b[7:4], rs, c);
    endfunction

    // one phase step once the current wait has run out
    function automatic t_state f_advance(t_state s, t_cfg c);
        t_state     r;
        logic [3:0] v_idx;
        r = s;
        v_idx = '0;
        unique case (s.phase)
            PH_POWERUP: begin
                r.init_step = STEP_NIB_FIRST;
                r = f_start_nibble(r, NIB_WAKE, 1'b0, c);
            end
            PH_EN_HIGH: begin
                r.enable_level = 1'b0;
                r.phase        = PH_EN_GAP;
                r.wait_count   = c.enable_gap;
            end
            PH_EN_GAP: begin
                r.phase = PH_POST;
                if (s.init_step >= STEP_NIB_FIRST && s.init_step <= STEP_NIB_LAST) begin
                    if (s.init_step == STEP_NIB_FIRST) begin
                        r.wait_count = c.init_first_gap;
                    end else if (s.init_step <= STEP_NIB_NEXT) begin
                        r.wait_count = c.init_next_gap;
                    end else begin
                        r.wait_count = '0;
                    end
                end else if (s.low_nibble_next) begin
                    r.low_nibble_next = 1'b0;
                    r = f_start_nibble(r, s.held_byte[3:0], s.rs_level, c);
                end else begin
                    r.wait_count = (!s.rs_level && s.held_byte < CMD_LONG_LIMIT)
                                   ? c.long_wait : c.short_wait;
                end
            end
            PH_POST: begin
                if (s.init_step >= STEP_NIB_FIRST && s.init_step <= STEP_NIB_NEXT) begin
                    r.init_step = s.init_step + 4'd1;
                    r = f_start_nibble(r, (r.init_step == STEP_NIB_LAST) ? NIB_FOUR_BIT
                                       : NIB_WAKE, 1'b0, c);
                end else if (s.init_step >= STEP_NIB_LAST &&
                             s.init_step < STEP_CMD_LAST) begin
                    r.init_step = s.init_step + 4'd1;
                    v_idx = r.init_step - STEP_CMD_FIRST;
                    r = f_start_byte(r, INIT_CMDS[v_idx[1:0]], 1'b0, c);
                end else if (s.init_step == STEP_CMD_LAST) begin
                    r.init_step  = STEP_CLEAR_WAIT;
                    r.wait_count = c.long_wait;
                end else begin
                    r.init_step  = STEP_NONE;
                    r.phase      = PH_IDLE;
                    r.wait_count = '0;
                end
            end
            default: begin
                r.phase      = PH_IDLE;
                r.wait_count = '0;
            end
        endcase
        return r;
    endfunction

    assign w_in_acc   = i_in.valid && i_in.ready;
    assign w_out_acc  = r_out_valid && o_out.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign i_cfg.ready = 1'b1;

    // apply the request, then pass any waits that are already over
    always_comb begin
        n_st  = r_st;
        n_res = '0;
        if (i_in.func == FUNC_TICK) begin
            if (r_st.phase != PH_IDLE && r_st.wait_count != 16'd0) begin
                n_st.wait_count = r_st.wait_count - 16'd1;
            end
        end else if (r_st.phase != PH_IDLE) begin
            n_res.rejected = 1'b1;
        end else if (i_in.func == FUNC_CMD) begin
            n_st.init_step = STEP_NONE;
            n_st = f_start_byte(n_st, i_in.byte_value, 1'b0, r_cfg);
        end else if (i_in.func == FUNC_DATA) begin
            n_st.init_step = STEP_NONE;
            n_st = f_start_byte(n_st, i_in.byte_value, 1'b1, r_cfg);
        end else begin
            n_st.init_step       = STEP_NONE;
            n_st.low_nibble_next = 1'b0;
            n_st.phase           = PH_POWERUP;
            n_st.wait_count      = r_cfg.powerup;
        end
        for (int k = 0; k < SETTLE_STEPS; k++) begin
            if (n_st.phase != PH_IDLE && n_st.wait_count == 16'd0) begin
                n_st = f_advance(n_st, r_cfg);
            end
        end
        n_res.pin_rs     = n_st.rs_level;
        n_res.pin_enable = n_st.enable_level;
        n_res.pin_data   = n_st.data_level;
        n_res.busy_res   = (n_st.phase != PH_IDLE);
    end

    // sequencer state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (w_in_acc) begin
            r_st <= n_st;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (w_out_acc) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid      = r_out_valid;
    assign o_out.pin_rs     = r_res.pin_rs;
    assign o_out.pin_enable = r_res.pin_enable;
    assign o_out.pin_data   = r_res.pin_data;
    assign o_out.busy_res   = r_res.busy_res;
    assign o_out.rejected   = r_res.rejected;

    // timing registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_high    <= 8'd1;
            r_cfg.enable_gap     <= 16'd100;
            r_cfg.short_wait     <= 16'd40;
            r_cfg.long_wait      <= 16'd2000;
            r_cfg.powerup        <= 16'd20000;
            r_cfg.init_first_gap <= 16'd5000;
            r_cfg.init_next_gap  <= 16'd150;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_ENABLE_HIGH:    r_cfg.enable_high    <= i_cfg.data[7:0];
                REG_ENABLE_GAP:     r_cfg.enable_gap     <= i_cfg.data;
                REG_SHORT_WAIT:     r_cfg.short_wait     <= i_cfg.data;
                REG_LONG_WAIT:      r_cfg.long_wait      <= i_cfg.data;
                REG_POWERUP:        r_cfg.powerup        <= i_cfg.data;
                REG_INIT_FIRST_GAP: r_cfg.init_first_gap <= i_cfg.data;
                REG_INIT_NEXT_GAP:  r_cfg.init_next_gap  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // enable is only ever high during the strobe phase
    a_enable_in_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.enable_level |-> r_st.phase == PH_EN_HIGH)
        else $error("enable high outside strobe phase");

    // a busy sequencer always has time left to wait
    a_busy_has_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.phase != PH_IDLE |-> r_st.wait_count != 16'd0)
        else $error("busy with an expired wait");

    // a dropped request is only reported while busy
    a_reject_when_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_res.rejected |-> r_res.busy_res)
        else $error("rejected while idle");

    // an accepted non-tick request from idle always starts work
    a_request_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && i_in.func != FUNC_TICK && r_st.phase == PH_IDLE
        |=> r_st.phase != PH_IDLE)
        else $error("request from idle did not start");

    // init progress stays within its sequence
    a_init_step_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st.init_step <= STEP_CLEAR_WAIT)
        else $error("init step out of range");

endmodule
